>>> rtl/pbd_pkg.sv
// Shared constant for the point-to-box squared distance test.
package pbd_pkg;

	// Width of the distance limit register and of the reported distance.
	localparam int LIMIT_BITS = 50;

endpackage

>>> rtl/pbd_if.sv
// Valid/ready channel interfaces for the query and result streams.
interface pbd_query_if #(
	parameter int COORD_BITS = 24
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	logic signed [COORD_BITS-1:0] corner_a_x;
	logic signed [COORD_BITS-1:0] corner_a_y;
	logic signed [COORD_BITS-1:0] corner_a_z;
	logic signed [COORD_BITS-1:0] corner_b_x;
	logic signed [COORD_BITS-1:0] corner_b_y;
	logic signed [COORD_BITS-1:0] corner_b_z;

	modport source (
		output valid, point_x, point_y, point_z,
		output corner_a_x, corner_a_y, corner_a_z,
		output corner_b_x, corner_b_y, corner_b_z,
		input  ready
	);

	modport sink (
		input  valid, point_x, point_y, point_z,
		input  corner_a_x, corner_a_y, corner_a_z,
		input  corner_b_x, corner_b_y, corner_b_z,
		output ready
	);
endinterface

interface pbd_result_if;
	import pbd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  exceeds;
	logic [LIMIT_BITS-1:0] dist_sq;

	modport source (
		output valid, exceeds, dist_sq,
		input  ready
	);

	modport sink (
		input  valid, exceeds, dist_sq,
		output ready
	);
endinterface

>>> rtl/pbd_axis.sv
// One axis: deltas to both corners, clamped nearest magnitude, then its square.
module pbd_axis #(
	parameter int COORD_BITS = 24
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [COORD_BITS-1:0]     p,
	input  logic signed [COORD_BITS-1:0]     a,
	input  logic signed [COORD_BITS-1:0]     b,
	output logic [2*(COORD_BITS+1)-1:0]      sq
);
	import pbd_pkg::*;

	localparam int D_W  = COORD_BITS + 1;
	localparam int SQ_W = 2 * D_W;

	logic signed [D_W-1:0] p_ext, a_ext, b_ext;
	logic signed [D_W-1:0] da, db;
	logic        [D_W-1:0] da_s1, db_s1;
	logic                  outside_s1;
	logic        [D_W-1:0] ma, mb;
	logic        [D_W-1:0] m_s2;
	logic     [SQ_W-1:0]   sq_s3;

	assign p_ext = {p[COORD_BITS-1], p};
	assign a_ext = {a[COORD_BITS-1], a};
	assign b_ext = {b[COORD_BITS-1], b};
	assign da    = a_ext - p_ext;
	assign db    = b_ext - p_ext;

	// stage 1: exact deltas and slab test (both nonzero, same sign)
	always_ff @(posedge clk) begin
		if (en) begin
			da_s1      <= da;
			db_s1      <= db;
			outside_s1 <= (da[D_W-1] == db[D_W-1]) && (da != '0) && (db != '0);
		end
	end

	// magnitude of a D_W-bit two's complement value fits D_W unsigned bits
	assign ma = da_s1[D_W-1] ? (~da_s1 + 1'b1) : da_s1;
	assign mb = db_s1[D_W-1] ? (~db_s1 + 1'b1) : db_s1;

	// stage 2: nearer face distance, zero when inside the slab
	always_ff @(posedge clk) begin
		if (en) begin
			if (!outside_s1) begin
				m_s2 <= '0;
			end else begin
				m_s2 <= (ma < mb) ? ma : mb;
			end
		end
	end

	// stage 3: square
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3 <= SQ_W'(m_s2) * SQ_W'(m_s2);
		end
	end

	assign sq = sq_s3;
endmodule

>>> rtl/pbd_sum.sv
// Sum of the three axis squares and the compare against the limit.
module pbd_sum #(
	parameter int COORD_BITS = 24
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [2*(COORD_BITS+1)-1:0]        sq_x,
	input  logic [2*(COORD_BITS+1)-1:0]        sq_y,
	input  logic [2*(COORD_BITS+1)-1:0]        sq_z,
	input  logic [pbd_pkg::LIMIT_BITS-1:0]     max_dist_sq,
	output logic                               exceeds,
	output logic [pbd_pkg::LIMIT_BITS-1:0]     dist_sq
);
	import pbd_pkg::*;

	localparam int SQ_W  = 2 * (COORD_BITS + 1);
	localparam int SUM_W = SQ_W + 2;
	localparam int CMP_W = (SUM_W > LIMIT_BITS) ? SUM_W : LIMIT_BITS;

	logic [SUM_W-1:0]      sum_s4;
	logic [CMP_W-1:0]      sum_ext;
	logic [CMP_W-1:0]      lim_ext;
	logic                  exceeds_s5;
	logic [LIMIT_BITS-1:0] dist_s5;

	// stage 4: full-width sum
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
		end
	end

	assign sum_ext = CMP_W'(sum_s4);
	assign lim_ext = CMP_W'(max_dist_sq);

	// stage 5: compare uses the untruncated sum; reported distance wraps
	always_ff @(posedge clk) begin
		if (en) begin
			exceeds_s5 <= sum_ext > lim_ext;
			dist_s5    <= sum_ext[LIMIT_BITS-1:0];
		end
	end

	assign exceeds = exceeds_s5;
	assign dist_sq = dist_s5;
endmodule

>>> rtl/point_box_dist_sq_exceeds_core.sv
// Top level: point to box squared distance test, five-stage pipeline.
//
//  port     | role              | contents
//  ---------+-------------------+------------------------------------------
//  query    | valid/ready sink  | point and two opposite corners, x/y/z
//  result   | valid/ready source| exceeds flag, 50-bit squared distance
//  cfg_*    | write only        | max_dist_sq limit, taken when cfg_we high
//
// One query per cycle sustained while results are taken; each result passes the
// delta, min magnitude, square, sum and compare registers in that order before
// it is offered.
// arst_n clears the stage valid bits and the limit register.
// When the result is held and not taken, every stage freezes together and
// query.ready drops in the same cycle; nothing is dropped or repeated.
module point_box_dist_sq_exceeds_core #(
	parameter int COORD_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	pbd_query_if.sink                      query,
	pbd_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [pbd_pkg::LIMIT_BITS-1:0] cfg_wdata
);
	import pbd_pkg::*;

	localparam int SQ_W = 2 * (COORD_BITS + 1);

	logic                  adv;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [LIMIT_BITS-1:0] max_dist_sq_q;
	logic [SQ_W-1:0]       sq_x, sq_y, sq_z;

	// pipeline moves whenever the output slot is empty or being drained
	assign adv         = !v_s5 || result.ready;
	assign query.ready = adv;
	assign result.valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_sq_q <= '0;
		end else if (cfg_we) begin
			max_dist_sq_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	pbd_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
		.clk (clk),
		.en  (adv),
		.p   (query.point_x),
		.a   (query.corner_a_x),
		.b   (query.corner_b_x),
		.sq  (sq_x)
	);

	pbd_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
		.clk (clk),
		.en  (adv),
		.p   (query.point_y),
		.a   (query.corner_a_y),
		.b   (query.corner_b_y),
		.sq  (sq_y)
	);

	pbd_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
		.clk (clk),
		.en  (adv),
		.p   (query.point_z),
		.a   (query.corner_a_z),
		.b   (query.corner_b_z),
		.sq  (sq_z)
	);

	pbd_sum #(.COORD_BITS(COORD_BITS)) u_sum (
		.clk         (clk),
		.en          (adv),
		.sq_x        (sq_x),
		.sq_y        (sq_y),
		.sq_z        (sq_z),
		.max_dist_sq (max_dist_sq_q),
		.exceeds     (result.exceeds),
		.dist_sq     (result.dist_sq)
	);
endmodule
